// ===== rtl/ipfrt_pkg.sv =====
// Package of the IP fragment reassembly tracker: field widths, result status
// codes, controller states and the command and status structs.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package ipfrt_pkg;

  localparam int unsigned DefTableEntries = 16;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned IdentW = 16;
  localparam int unsigned OffW   = 16;
  localparam int unsigned LenW   = 16;
  localparam int unsigned TotW   = 17;
  localparam int unsigned StatW  = 3;

  // Result status codes.
  localparam logic [StatW-1:0] RsComplete  = 3'd0;
  localparam logic [StatW-1:0] RsMissing   = 3'd1;
  localparam logic [StatW-1:0] RsDuplicate = 3'd2;
  localparam logic [StatW-1:0] RsMismatch  = 3'd3;
  localparam logic [StatW-1:0] RsDropped   = 3'd4;
  localparam logic [StatW-1:0] RsEnd       = 3'd5;

  // Request operation codes.
  localparam logic OpFragment = 1'b0;
  localparam logic OpFlush    = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StLook,
    StUpd,
    StFlush,
    StEnd
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // register the accepted request
    logic look;      // register the table lookup of the held request
    logic upd;       // commit the fragment update and any result
    logic fl_start;  // rewind the flush walk
    logic walk;      // flush walk in progress, table read follows the walk index
    logic fl_step;   // report and clear the current slot, advance
    logic end_emit;  // load the end-of-report result
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_flush;   // held request is a flush
    logic upd_emits;  // held fragment gives a result
    logic slot_valid; // current flush slot is open
    logic fl_last;    // current flush slot is the last one
    logic out_free;   // result register can take a new result this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ipfrt_req_if.sv =====
// Request channel of the IP fragment reassembly tracker: valid/ready handshake
// with one fragment descriptor or flush request. Depends on ipfrt_pkg.
`default_nettype none

interface ipfrt_req_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [ipfrt_pkg::AddrW-1:0]     src_addr;
  logic [ipfrt_pkg::IdentW-1:0]    ident;
  logic [ipfrt_pkg::OffW-1:0]      frag_offset;
  logic                            more_frags;
  logic [ipfrt_pkg::LenW-1:0]      frag_length;

  modport source (
    output valid, operation, src_addr, ident, frag_offset, more_frags, frag_length,
    input  ready
  );

  modport sink (
    input  valid, operation, src_addr, ident, frag_offset, more_frags, frag_length,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/ipfrt_res_if.sv =====
// Result channel of the IP fragment reassembly tracker: valid/ready handshake
// with one result. Depends on ipfrt_pkg.
`default_nettype none

interface ipfrt_res_if;
  logic                            valid;
  logic                            ready;
  logic [ipfrt_pkg::AddrW-1:0]     res_addr;
  logic [ipfrt_pkg::IdentW-1:0]    res_ident;
  logic [ipfrt_pkg::TotW-1:0]      total_length;
  logic [ipfrt_pkg::StatW-1:0]     status;
  logic                            last;

  modport source (
    output valid, res_addr, res_ident, total_length, status, last,
    input  ready
  );

  modport sink (
    input  valid, res_addr, res_ident, total_length, status, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/ipfrt_ctrl.sv =====
// Controller of the IP fragment reassembly tracker: sequences lookup, update
// and flush walk. Depends on ipfrt_pkg; drives the datapath ipfrt_dp.
`default_nettype none

module ipfrt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  ipfrt_pkg::dp_stat_t   stat_i,
  output ipfrt_pkg::ctl_cmd_t   cmd_o
);
  import ipfrt_pkg::*;

  ctl_state_e state_q, state_d;
  logic       upd_go;
  logic       fl_go;

  assign upd_go = !stat_i.upd_emits || stat_i.out_free;
  assign fl_go  = !stat_i.slot_valid || stat_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          state_d = StLook;
        end
      end
      StLook: begin
        state_d = stat_i.is_flush ? StFlush : StUpd;
      end
      StUpd: begin
        if (upd_go) begin
          state_d = req_valid_i ? StLook : StIdle;
        end
      end
      StFlush: begin
        if (fl_go && stat_i.fl_last) begin
          state_d = StEnd;
        end
      end
      StEnd: begin
        if (stat_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
      end
      StLook: begin
        cmd_o.look     = 1'b1;
        cmd_o.fl_start = stat_i.is_flush;
      end
      StUpd: begin
        cmd_o.upd   = upd_go;
        req_ready_o = upd_go;
      end
      StFlush: begin
        cmd_o.walk    = 1'b1;
        cmd_o.fl_step = fl_go;
      end
      StEnd: begin
        cmd_o.end_emit = stat_i.out_free;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
    cmd_o.capture = req_valid_i && req_ready_o;
  end

endmodule

`default_nettype wire

// ===== rtl/ipfrt_dp.sv =====
// Datapath of the IP fragment reassembly tracker: request register, entry
// table, lookup, length update, flush classification and result register.
// Depends on ipfrt_pkg; controlled by ipfrt_ctrl.
`default_nettype none

module ipfrt_dp #(
  parameter int unsigned TableEntries = ipfrt_pkg::DefTableEntries
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ipfrt_pkg::ctl_cmd_t           cmd_i,
  output ipfrt_pkg::dp_stat_t           stat_o,
  input  logic                          operation_i,
  input  logic [ipfrt_pkg::AddrW-1:0]   src_addr_i,
  input  logic [ipfrt_pkg::IdentW-1:0]  ident_i,
  input  logic [ipfrt_pkg::OffW-1:0]    frag_offset_i,
  input  logic                          more_frags_i,
  input  logic [ipfrt_pkg::LenW-1:0]    frag_length_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [ipfrt_pkg::AddrW-1:0]   res_addr_o,
  output logic [ipfrt_pkg::IdentW-1:0]  res_ident_o,
  output logic [ipfrt_pkg::TotW-1:0]    total_length_o,
  output logic [ipfrt_pkg::StatW-1:0]   status_o,
  output logic                          last_o
);
  import ipfrt_pkg::*;

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);
  localparam logic [TotW-1:0] LenMax = '1;

  // Held request.
  logic              req_op_q;
  logic [AddrW-1:0]  req_addr_q;
  logic [IdentW-1:0] req_ident_q;
  logic [OffW-1:0]   req_off_q;
  logic              req_more_q;
  logic [LenW-1:0]   req_len_q;

  // Entry table.
  logic [TableEntries-1:0] valid_q;
  logic [AddrW-1:0]        addr_q  [TableEntries];
  logic [IdentW-1:0]       ident_q [TableEntries];
  logic [TotW-1:0]         rcv_q   [TableEntries];
  logic [TotW-1:0]         tot_q   [TableEntries];

  // Lookup results.
  logic            hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic            free_ok_q, free_ok_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;

  logic [IdxW-1:0] walk_idx_q;
  logic [IdxW-1:0] rd_idx;

  logic [TotW-1:0] rd_rcv, rd_tot;
  logic [TotW:0]   rcv_sum;
  logic [TotW-1:0] rcv_new;
  logic [TotW-1:0] off_len;
  logic [TotW-1:0] tot_new;
  logic            complete;
  logic            unfrag;
  logic            upd_emits;
  logic            out_free;
  logic            res_load;
  logic [StatW-1:0] fl_status;

  // Result register.
  logic              res_valid_q;
  logic [AddrW-1:0]  res_addr_q,  res_addr_d;
  logic [IdentW-1:0] res_ident_q, res_ident_d;
  logic [TotW-1:0]   res_tot_q,   res_tot_d;
  logic [StatW-1:0]  res_stat_q,  res_stat_d;
  logic              res_last_q,  res_last_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_op_q    <= operation_i;
      req_addr_q  <= src_addr_i;
      req_ident_q <= ident_i;
      req_off_q   <= frag_offset_i;
      req_more_q  <= more_frags_i;
      req_len_q   <= frag_length_i;
    end
  end

  // Parallel match over all slots; the lowest matching and lowest free slot win.
  always_comb begin
    hit_d      = 1'b0;
    hit_idx_d  = '0;
    free_ok_d  = 1'b0;
    free_idx_d = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (valid_q[i] && addr_q[i] == req_addr_q && ident_q[i] == req_ident_q) begin
        hit_d     = 1'b1;
        hit_idx_d = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free_ok_d  = 1'b1;
        free_idx_d = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      hit_q      <= hit_d;
      hit_idx_q  <= hit_idx_d;
      free_ok_q  <= free_ok_d;
      free_idx_q <= free_idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_idx_q <= '0;
    end else if (cmd_i.fl_start) begin
      walk_idx_q <= '0;
    end else if (cmd_i.fl_step) begin
      walk_idx_q <= walk_idx_q + 1'b1;
    end
  end

  // One read port on the length fields, shared by update and flush walk.
  assign rd_idx = cmd_i.walk ? walk_idx_q : hit_idx_q;
  assign rd_rcv = rcv_q[rd_idx];
  assign rd_tot = tot_q[rd_idx];

  assign unfrag   = (req_off_q == '0) && !req_more_q;
  assign rcv_sum  = {1'b0, rd_rcv} + (TotW + 1)'(req_len_q);
  assign rcv_new  = rcv_sum[TotW] ? LenMax : rcv_sum[TotW-1:0];
  assign off_len  = TotW'(req_off_q) + TotW'(req_len_q);
  assign tot_new  = req_more_q ? rd_tot : off_len;
  assign complete = (tot_new != '0) && (tot_new == rcv_new);

  assign upd_emits = unfrag || (hit_q && complete) || (!hit_q && !free_ok_q);

  always_comb begin
    if (rd_tot == '0) begin
      fl_status = RsMissing;
    end else if (rd_tot < rd_rcv) begin
      fl_status = RsDuplicate;
    end else begin
      fl_status = RsMismatch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.upd && !unfrag) begin
      if (hit_q) begin
        if (complete) begin
          valid_q[hit_idx_q] <= 1'b0;
        end
      end else if (free_ok_q) begin
        valid_q[free_idx_q] <= 1'b1;
      end
    end else if (cmd_i.fl_step) begin
      valid_q[walk_idx_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd && !unfrag) begin
      if (hit_q) begin
        rcv_q[hit_idx_q] <= rcv_new;
        tot_q[hit_idx_q] <= tot_new;
      end else if (free_ok_q) begin
        addr_q[free_idx_q]  <= req_addr_q;
        ident_q[free_idx_q] <= req_ident_q;
        rcv_q[free_idx_q]   <= TotW'(req_len_q);
        tot_q[free_idx_q]   <= req_more_q ? '0 : off_len;
      end
    end
  end

  assign out_free = !res_valid_q || res_ready_i;
  assign res_load = (cmd_i.upd && upd_emits) || (cmd_i.fl_step && valid_q[walk_idx_q]) ||
                    cmd_i.end_emit;

  always_comb begin
    res_addr_d  = req_addr_q;
    res_ident_d = req_ident_q;
    res_tot_d   = '0;
    res_stat_d  = RsDropped;
    res_last_d  = 1'b0;
    if (cmd_i.end_emit) begin
      res_addr_d  = '0;
      res_ident_d = '0;
      res_stat_d  = RsEnd;
      res_last_d  = 1'b1;
    end else if (cmd_i.walk) begin
      res_addr_d  = addr_q[walk_idx_q];
      res_ident_d = ident_q[walk_idx_q];
      res_stat_d  = fl_status;
    end else if (unfrag) begin
      res_tot_d  = TotW'(req_len_q);
      res_stat_d = RsComplete;
    end else if (hit_q) begin
      res_tot_d  = tot_new;
      res_stat_d = RsComplete;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_addr_q  <= res_addr_d;
      res_ident_q <= res_ident_d;
      res_tot_q   <= res_tot_d;
      res_stat_q  <= res_stat_d;
      res_last_q  <= res_last_d;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign res_addr_o     = res_addr_q;
  assign res_ident_o    = res_ident_q;
  assign total_length_o = res_tot_q;
  assign status_o       = res_stat_q;
  assign last_o         = res_last_q;

  assign stat_o.is_flush   = (req_op_q == OpFlush);
  assign stat_o.upd_emits  = upd_emits;
  assign stat_o.slot_valid = valid_q[walk_idx_q];
  assign stat_o.fl_last    = (walk_idx_q == LastIdx);
  assign stat_o.out_free   = out_free;

endmodule

`default_nettype wire

// ===== rtl/ip_fragment_reassembly_tracker.sv =====
// Top level of the IP fragment reassembly tracker. A fragment request is first matched
// against every table slot at once, then the matching slot is read, updated and written
// back; the next fragment is accepted in the update state, while the last one commits,
// unless the update waits for a free result register. A flush runs the lookup, visits
// each table slot in turn and then emits the end marker, waiting while results stall.
// Reset clears the slot valid bits and the controller at once; no clearing pass runs.
// Depends on ipfrt_pkg, ipfrt_req_if, ipfrt_res_if, ipfrt_ctrl and ipfrt_dp.
`default_nettype none

module ip_fragment_reassembly_tracker #(
  parameter int unsigned TableEntries = ipfrt_pkg::DefTableEntries
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ipfrt_req_if.sink          req_i,
  ipfrt_res_if.source        res_o
);
  import ipfrt_pkg::*;

  // The controller and the datapath talk only through these two structs.
  ctl_cmd_t cmd;
  dp_stat_t stat;

  // The controller owns the request handshake. It is ready when idle, and also in
  // the cycle in which a fragment update commits, so that a following request is
  // taken without a gap. Requests are held in the datapath while they are worked on.
  ipfrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the slot table, the lookup and length arithmetic and the
  // result register. The result register parts the two sides: a finished result
  // waits there while the next request is already being looked up.
  ipfrt_dp #(
    .TableEntries (TableEntries)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .operation_i    (req_i.operation),
    .src_addr_i     (req_i.src_addr),
    .ident_i        (req_i.ident),
    .frag_offset_i  (req_i.frag_offset),
    .more_frags_i   (req_i.more_frags),
    .frag_length_i  (req_i.frag_length),
    .res_valid_o    (res_o.valid),
    .res_ready_i    (res_o.ready),
    .res_addr_o     (res_o.res_addr),
    .res_ident_o    (res_o.res_ident),
    .total_length_o (res_o.total_length),
    .status_o       (res_o.status),
    .last_o         (res_o.last)
  );

endmodule

`default_nettype wire
